@@ rtl/hia_pkg.sv @@
`default_nettype none

package hia_pkg;

    // fixed field widths
    localparam int KIND_W   = 2;
    localparam int IDX_W    = 6;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 7;

    // capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // outcome of one request; use_ring selects the ring read data as granted
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    granted;
        logic                use_ring;
    } hia_result_t;

endpackage

`default_nettype wire

@@ rtl/hia_ring_mem.sv @@
`default_nettype none

module hia_ring_mem
    import hia_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [IDX_W-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [IDX_W-1:0]  rd_data
);

    logic [IDX_W-1:0] mem [DEPTH];
    logic [IDX_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, held until the next pop
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/hia_ctrl.sv @@
`default_nettype none

module hia_ctrl
    import hia_pkg::*;
#(
    parameter int MAX_HANDLES = 64,
    parameter int PTR_W       = 6,
    parameter int CNT_W       = 7
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [CAP_W-1:0]  cfg_wr_data,
    input  wire logic              fire,
    input  wire logic [KIND_W-1:0] kind,
    input  wire logic [IDX_W-1:0]  index,
    output logic                   ready,
    output hia_result_t            result,
    output logic                   mem_wr_en,
    output logic [PTR_W-1:0]       mem_wr_addr,
    output logic [IDX_W-1:0]       mem_wr_data,
    output logic                   mem_rd_en,
    output logic [PTR_W-1:0]       mem_rd_addr
);

    // compare width wide enough for capacity, counts and indices
    localparam int CW = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0] capacity_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] bump_reg, bump_next;

    logic [CW-1:0] cap_ext, eff_cap;
    logic [CW-1:0] head_ext, tail_ext, count_ext, bump_ext, index_ext;
    logic [CW-1:0] head_inc, tail_inc;
    logic [PTR_W-1:0] head_adv, tail_adv;
    logic          head_wrap, tail_wrap;

    // capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // clamp capacity to 1..MAX_HANDLES
    always_comb begin
        cap_ext = CW'(capacity_reg);
        if (cap_ext == '0) begin
            eff_cap = CW'(1);
        end else if (cap_ext > CW'(MAX_HANDLES)) begin
            eff_cap = CW'(MAX_HANDLES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign head_ext  = CW'(head_reg);
    assign tail_ext  = CW'(tail_reg);
    assign count_ext = CW'(count_reg);
    assign bump_ext  = CW'(bump_reg);
    assign index_ext = CW'(index);

    // pointers left beyond a lowered capacity are rewrapped first
    assign head_wrap = (head_ext >= eff_cap);
    assign tail_wrap = (tail_ext >= eff_cap);
    assign ready     = !head_wrap && !tail_wrap;

    // ring pointer advance with wrap at capacity
    assign head_inc = head_ext + CW'(1);
    assign tail_inc = tail_ext + CW'(1);
    assign head_adv = (head_inc >= eff_cap) ? '0 : head_inc[PTR_W-1:0];
    assign tail_adv = (tail_inc >= eff_cap) ? '0 : tail_inc[PTR_W-1:0];

    // request decode and state update
    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        bump_next       = bump_reg;
        result.status   = ST_OK;
        result.granted  = '0;
        result.use_ring = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = tail_reg;
        mem_wr_data     = index;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = head_reg;
        if (!fire) begin
            if (head_wrap) begin
                head_next = head_reg - eff_cap[PTR_W-1:0];
            end
            if (tail_wrap) begin
                tail_next = tail_reg - eff_cap[PTR_W-1:0];
            end
        end else begin
            unique case (kind)
                KIND_ALLOC: begin
                    if (count_reg != '0) begin
                        mem_rd_en       = 1'b1;
                        result.use_ring = 1'b1;
                        head_next       = head_adv;
                        count_next      = count_reg - CNT_W'(1);
                    end else if (bump_ext < eff_cap) begin
                        result.granted = bump_ext[IDX_W-1:0];
                        bump_next      = bump_reg + CNT_W'(1);
                    end else begin
                        result.status = ST_EXHAUSTED;
                    end
                end
                KIND_RELEASE: begin
                    if (index_ext >= eff_cap) begin
                        result.status = ST_RANGE;
                    end else if (count_ext >= eff_cap) begin
                        result.status = ST_FULL;
                    end else begin
                        mem_wr_en  = 1'b1;
                        tail_next  = tail_adv;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                KIND_CLEAR: begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                    bump_next  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // pointer and counter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            bump_reg  <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            bump_reg  <= bump_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a request is only processed with both pointers inside capacity
    a_fire_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> ready)
        else $error("request processed while pointers rewrap");

    // one request touches the ring at most once
    a_one_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_wr_en && mem_rd_en))
        else $error("ring read and write in one cycle");

    // clear empties the ring and the bump counter
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && kind == KIND_CLEAR) |=> (count_reg == '0 && bump_reg == '0))
        else $error("clear left state behind");

    // accepted release grows the ring by one
    a_push: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("ring count not incremented on push");
`endif

endmodule

`default_nettype wire

@@ rtl/handle_index_allocator.sv @@
`default_nettype none

// Handle index allocator. Allocate requests pop the oldest index from a FIFO
// recycle ring, fall back to a bump counter of never-used indices, and report
// exhausted when both are spent; releases push onto the ring or are rejected
// (out of range, ring full); clear empties ring and counter. One request is
// taken per cycle while the decision logic is ready and the result slot is
// free. A request passes the input register, the decision logic and the
// result register before its result shows on m_tvalid (the ring read is
// registered in the ring memory beside the result register). After a
// capacity write that leaves a ring pointer at or beyond the new capacity,
// requests are held while the pointers are rewrapped, one subtraction per
// cycle; one request can still enter the input register, after which s_tready
// stays low. The ring needs no clearing pass after reset. Granted indices
// are 6 bits wide.
module handle_index_allocator
    import hia_pkg::*;
#(
    parameter int MAX_HANDLES = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // configuration: capacity
    input  wire logic             cfg_wr_en,
    input  wire logic [CAP_W-1:0] cfg_wr_data,
    // request channel
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // index[5:0], zero[7:6]
    input  wire logic [1:0]       s_tuser,   // kind[1:0]
    // result channel
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata    // status[1:0], granted[7:2]
);

    localparam int PTR_W = $clog2(MAX_HANDLES);
    localparam int CNT_W = $clog2(MAX_HANDLES + 1);

    logic              in_valid_reg;
    logic [KIND_W-1:0] in_kind_reg;
    logic [IDX_W-1:0]  in_index_reg;

    logic              out_valid_reg;
    hia_result_t       out_result_reg;

    logic              fire;
    logic              ctrl_ready;
    hia_result_t       result;
    logic              mem_wr_en;
    logic [PTR_W-1:0]  mem_wr_addr;
    logic [IDX_W-1:0]  mem_wr_data;
    logic              mem_rd_en;
    logic [PTR_W-1:0]  mem_rd_addr;
    logic [IDX_W-1:0]  mem_rd_data;

    // a request moves on when it is decided and the result slot frees up
    assign fire     = in_valid_reg && ctrl_ready && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg  <= s_tuser;
            in_index_reg <= s_tdata[IDX_W-1:0];
        end
    end

    hia_ctrl #(
        .MAX_HANDLES (MAX_HANDLES),
        .PTR_W       (PTR_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .kind        (in_kind_reg),
        .index       (in_index_reg),
        .ready       (ctrl_ready),
        .result      (result),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr)
    );

    hia_ring_mem #(
        .DEPTH   (MAX_HANDLES),
        .ADDR_W  (PTR_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_result_reg <= result;
        end
    end

    // result transfer
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(out_result_reg.use_ring ? mem_rd_data : out_result_reg.granted),
                       out_result_reg.status};

endmodule

`default_nettype wire
